// ===== hdl/dd_kin_pkg.sv =====
// shared types, constants and helper functions for the kinematics step block
`default_nettype none
package dd_kin_pkg;

   typedef logic signed [23:0] vel_type;
   typedef logic signed [31:0] pos_type;
   typedef logic [15:0]        head_type;
   typedef logic [22:0]        lim_type;
   typedef logic signed [24:0] wide_type;

   localparam int TIME_STEP_SHIFT = 8;
   localparam int MID_SHIFT  = 26 + TIME_STEP_SHIFT;
   localparam int HEAD_SHIFT = 33 + TIME_STEP_SHIFT;
   localparam int POS_SHIFT  = 31 + TIME_STEP_SHIFT;

   localparam logic signed [31:0] RECIP_TWO_PI = 32'sd683565276;
   localparam logic signed [31:0] CORDIC_GAIN  = 32'sd652032874;
   localparam logic signed [24:0] QUARTER_TURN = 25'sd4194304;
   localparam logic signed [24:0] HALF_TURN    = 25'sd8388608;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_BASE   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FWD     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VEL     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ANG     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIN_ACCEL   = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIN_DECEL   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANG_ACCEL   = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WHEEL   = 4'd7;

   typedef struct packed {
      logic        start;
      logic        neg;
      logic [46:0] mag;
      logic [32:0] den;
   } div_req_type;

   typedef struct packed {
      logic        start;
      logic [23:0] angle;
   } cord_req_type;

   function automatic logic signed [24:0] atan_turn(input logic [3:0] idx);
      logic signed [24:0] r;
      case (idx)
         4'd0:    r = 25'sd2097152;
         4'd1:    r = 25'sd1238021;
         4'd2:    r = 25'sd654136;
         4'd3:    r = 25'sd332050;
         4'd4:    r = 25'sd166666;
         4'd5:    r = 25'sd83416;
         4'd6:    r = 25'sd41718;
         4'd7:    r = 25'sd20860;
         4'd8:    r = 25'sd10430;
         4'd9:    r = 25'sd5215;
         4'd10:   r = 25'sd2608;
         4'd11:   r = 25'sd1304;
         4'd12:   r = 25'sd652;
         4'd13:   r = 25'sd326;
         4'd14:   r = 25'sd163;
         default: r = 25'sd81;
      endcase
      return r;
   endfunction

   function automatic wide_type clamp25(input wide_type v, input wide_type lo,
                                        input wide_type hi);
      wide_type r;
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   function automatic logic [32:0] abs33(input logic signed [32:0] v);
      logic signed [32:0] n;
      n = -v;
      return v[32] ? n : v;
   endfunction

   function automatic vel_type sat24(input logic signed [32:0] v);
      vel_type r;
      if (v > 33'sd8388607)       r = 24'sh7fffff;
      else if (v < -33'sd8388608) r = 24'sh800000;
      else                        r = v[23:0];
      return r;
   endfunction

   function automatic pos_type sat32(input logic signed [33:0] v);
      pos_type r;
      if (v > 34'sd2147483647)       r = 32'sh7fffffff;
      else if (v < -34'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   function automatic vel_type rate_step(input vel_type cur, input vel_type tgt,
                                         input lim_type up, input lim_type down);
      logic        same;
      logic        faster;
      logic [24:0] acur;
      logic [24:0] atgt;
      wide_type    lim;
      wide_type    d;
      wide_type    s;
      same   = !((cur < 0 && tgt > 0) || (cur > 0 && tgt < 0));
      acur   = cur[23] ? -{cur[23], cur} : {cur[23], cur};
      atgt   = tgt[23] ? -{tgt[23], tgt} : {tgt[23], tgt};
      faster = same && (atgt > acur);
      lim    = faster ? {2'b00, up} : {2'b00, down};
      d      = {tgt[23], tgt} - {cur[23], cur};
      if (d < -lim) d = -lim;
      if (d > lim)  d = lim;
      s      = {cur[23], cur} + d;
      return s[23:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/dd_kin_if.sv =====
// item channel interfaces for the kinematics step block
`default_nettype none
interface dd_kin_req_if;
   import dd_kin_pkg::*;
   logic     valid;
   logic     ready;
   logic     command;
   vel_type  lin_cmd;
   vel_type  ang_cmd;
   pos_type  pose_x;
   pos_type  pose_y;
   head_type pose_heading;
   vel_type  pose_velocity;
   modport source (output valid, command, lin_cmd, ang_cmd, pose_x, pose_y,
                   pose_heading, pose_velocity, input ready);
   modport sink (input valid, command, lin_cmd, ang_cmd, pose_x, pose_y,
                 pose_heading, pose_velocity, output ready);
endinterface

interface dd_kin_rsp_if;
   import dd_kin_pkg::*;
   logic     valid;
   logic     ready;
   pos_type  out_x;
   pos_type  out_y;
   head_type out_heading;
   vel_type  out_linear;
   vel_type  out_angular;
   vel_type  left_wheel;
   vel_type  right_wheel;
   modport source (output valid, out_x, out_y, out_heading, out_linear, out_angular,
                   left_wheel, right_wheel, input ready);
   modport sink (input valid, out_x, out_y, out_heading, out_linear, out_angular,
                 left_wheel, right_wheel, output ready);
endinterface
`default_nettype wire

// ===== hdl/dd_kin_div.sv =====
// restoring divider, one quotient bit per cycle, truncates toward zero
`default_nettype none
module dd_kin_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dd_kin_pkg::div_req_type  req,
   output dd_kin_pkg::vel_type           quot,
   output logic                          done
);
   import dd_kin_pkg::*;

   logic [32:0] rem_ff, rem_in;
   logic [23:0] num_ff, num_in;
   logic [23:0] q_ff, q_in;
   logic [32:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[23]};
      if (req.start) begin
         rem_in  = {10'b0, req.mag[46:24]};
         num_in  = req.mag[23:0];
         den_in  = req.den;
         neg_in  = req.neg;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 33'(trial - {1'b0, den_ff});
            q_in   = {q_ff[22:0], 1'b1};
         end else begin
            rem_in = trial[32:0];
            q_in   = {q_ff[22:0], 1'b0};
         end
         num_in = {num_ff[22:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign quot = neg_ff ? -q_ff : q_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// ===== hdl/dd_kin_cordic.sv =====
// rotation mode cordic, one micro-rotation per cycle, sixteen in all
`default_nettype none
module dd_kin_cordic (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dd_kin_pkg::cord_req_type  req,
   output dd_kin_pkg::pos_type            cos_out,
   output dd_kin_pkg::pos_type            sin_out,
   output logic                           done
);
   import dd_kin_pkg::*;

   pos_type     x_ff, x_in;
   pos_type     y_ff, y_in;
   wide_type    z_ff, z_in;
   logic        neg_ff, neg_in;
   logic [3:0]  iter_ff, iter_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   wide_type    z0;
   pos_type     xs;
   pos_type     ys;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      z0      = {req.angle[23], req.angle};
      xs      = x_ff >>> iter_ff;
      ys      = y_ff >>> iter_ff;
      if (req.start) begin
         // fold into +-quarter turn, flip the result afterwards
         if (z0 > QUARTER_TURN) begin
            z_in   = z0 - HALF_TURN;
            neg_in = 1'b1;
         end else if (z0 < -QUARTER_TURN) begin
            z_in   = z0 + HALF_TURN;
            neg_in = 1'b1;
         end else begin
            z_in   = z0;
            neg_in = 1'b0;
         end
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[24]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_turn(iter_ff);
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_turn(iter_ff);
         end
         iter_in = iter_ff + 4'd1;
         if (iter_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;
   assign done    = done_ff;
endmodule
`default_nettype wire

// ===== hdl/diff_drive_kinematics_step.sv =====
// top level: differential drive kinematics step with limits and rate limiting
//
//   channel   dir  handshake        contents
//   req_chan  in   valid/ready      command, targets, pose to load
//   rsp_chan  out  valid/ready      pose, velocities, wheel speeds
//   csr_*     in   write enable     eight limit registers, 24-bit data
//
// a load item passes through the load and finish states before the next accept; an
// advance item runs two wheel limit passes, with a rate step between them, and in
// each pass the divider scales both velocities only when a wheel is over its limit,
// then the cordic; the divider (two divisions per pass) and the cordic sit beside
// one 25x32 multiplier that the sequencer shares between its states
// reset is synchronous and clears state, pose and limits to their defaults
// one item at a time; a finished result waits in the output register and the
// sequencer holds only if that register is still full when the next result is ready
`default_nettype none
module diff_drive_kinematics_step (
   input  wire logic                                clock,
   input  wire logic                                reset,
   dd_kin_req_if.sink                               req_chan,
   dd_kin_rsp_if.source                             rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic [dd_kin_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [dd_kin_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dd_kin_pkg::*;

   // sequencer states
   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_LOAD    = 5'd1;
   localparam logic [4:0] ST_OFF     = 5'd2;
   localparam logic [4:0] ST_ABS     = 5'd3;
   localparam logic [4:0] ST_PEAK    = 5'd4;
   localparam logic [4:0] ST_DIVL_GO = 5'd5;
   localparam logic [4:0] ST_DIVL_WT = 5'd6;
   localparam logic [4:0] ST_DIVA_GO = 5'd7;
   localparam logic [4:0] ST_DIVA_WT = 5'd8;
   localparam logic [4:0] ST_RATE    = 5'd9;
   localparam logic [4:0] ST_SUMS    = 5'd10;
   localparam logic [4:0] ST_MULW    = 5'd11;
   localparam logic [4:0] ST_MID     = 5'd12;
   localparam logic [4:0] ST_CORD    = 5'd13;
   localparam logic [4:0] ST_POSX    = 5'd14;
   localparam logic [4:0] ST_POSY    = 5'd15;
   localparam logic [4:0] ST_WHEEL   = 5'd16;
   localparam logic [4:0] ST_FINISH  = 5'd17;

   // limit registers
   lim_type  ht_ff, maxf_ff, maxa_ff, lacc_ff, ldec_ff, aacc_ff, maxw_ff;
   vel_type  minv_ff;

   // architectural state
   pos_type  pos_x_ff, pos_x_in;
   pos_type  pos_y_ff, pos_y_in;
   head_type head_ff, head_in;
   vel_type  lin_ff, lin_in;
   vel_type  ang_ff, ang_in;

   // working registers
   logic [4:0]         state_ff, state_in;
   logic               pass_ff, pass_in;
   vel_type            wl_ff, wl_in;
   vel_type            wa_ff, wa_in;
   logic signed [56:0] prod_ff;
   logic [32:0]        labs_ff, labs_in;
   logic [32:0]        rabs_ff, rabs_in;
   logic [32:0]        peak_ff, peak_in;
   wide_type           vsum_ff, vsum_in;
   wide_type           wsum_ff, wsum_in;
   head_type           hdel_ff, hdel_in;
   pos_type            sin_ff, sin_in;
   vel_type            lw_ff, lw_in;
   vel_type            rw_ff, rw_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   pos_type  ox_ff, ox_in;
   pos_type  oy_ff, oy_in;
   head_type oh_ff, oh_in;
   vel_type  ol_ff, ol_in;
   vel_type  oa_ff, oa_in;
   vel_type  olw_ff, olw_in;
   vel_type  orw_ff, orw_in;

   // shared multiplier operands
   wide_type           mul_a;
   pos_type            mul_b;

   div_req_type        div_req;
   vel_type            div_quot;
   logic               div_done;
   cord_req_type       cord_req;
   pos_type            cord_cos;
   pos_type            cord_sin;
   logic               cord_done;

   logic signed [56:0] sh_mid;
   logic signed [56:0] sh_head;
   logic signed [56:0] sh_pos;
   logic signed [31:0] off;
   logic signed [56:0] prod_neg;
   wide_type           maxw_s;
   wide_type           v_tmp;
   logic signed [32:0] lsum;
   logic signed [32:0] rsum;

   dd_kin_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .quot  (div_quot),
      .done  (div_done)
   );

   dd_kin_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .req     (cord_req),
      .cos_out (cord_cos),
      .sin_out (cord_sin),
      .done    (cord_done)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign sh_mid   = prod_ff >>> MID_SHIFT;
   assign sh_head  = prod_ff >>> HEAD_SHIFT;
   assign sh_pos   = prod_ff >>> POS_SHIFT;
   assign off      = prod_ff[47:16];
   assign prod_neg = -prod_ff;
   assign maxw_s   = {2'b00, maxw_ff};
   assign lsum     = {{9{wl_ff[23]}}, wl_ff} - {off[31], off};
   assign rsum     = {{9{wl_ff[23]}}, wl_ff} + {off[31], off};

   // divider takes the magnitude of the product and the current peak
   always_comb begin
      div_req.start = (state_ff == ST_DIVL_GO) || (state_ff == ST_DIVA_GO);
      div_req.neg   = prod_ff[56];
      div_req.mag   = prod_ff[56] ? prod_neg[46:0] : prod_ff[46:0];
      div_req.den   = peak_ff;
   end

   // midpoint heading in 2^-24 turn
   always_comb begin
      cord_req.start = (state_ff == ST_MID);
      cord_req.angle = {head_ff, 8'b0} + sh_mid[23:0];
   end

   // operand select for the one multiplier
   always_comb begin
      case (state_ff)
         ST_PEAK, ST_DIVL_GO: begin
            mul_a = {wl_ff[23], wl_ff};
            mul_b = {9'b0, maxw_ff};
         end
         ST_DIVL_WT: begin
            mul_a = {wa_ff[23], wa_ff};
            mul_b = {9'b0, maxw_ff};
         end
         ST_MULW: begin
            mul_a = wsum_ff;
            mul_b = RECIP_TWO_PI;
         end
         ST_CORD: begin
            mul_a = vsum_ff;
            mul_b = cord_cos;
         end
         ST_POSX: begin
            mul_a = vsum_ff;
            mul_b = sin_ff;
         end
         default: begin
            // wheel offset: angular times half track
            mul_a = {wa_ff[23], wa_ff};
            mul_b = {9'b0, ht_ff};
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      wl_in        = wl_ff;
      wa_in        = wa_ff;
      labs_in      = labs_ff;
      rabs_in      = rabs_ff;
      peak_in      = peak_ff;
      vsum_in      = vsum_ff;
      wsum_in      = wsum_ff;
      hdel_in      = hdel_ff;
      sin_in       = sin_ff;
      lw_in        = lw_ff;
      rw_in        = rw_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      lin_in       = lin_ff;
      ang_in       = ang_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      oh_in        = oh_ff;
      ol_in        = ol_ff;
      oa_in        = oa_ff;
      olw_in       = olw_ff;
      orw_in       = orw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      v_tmp        = '0;

      case (state_ff)
         ST_IDLE: begin
            pass_in = 1'b0;
            if (req_chan.valid) begin
               if (req_chan.command) begin
                  // load: pose goes in now, velocity clamp first to the linear limits
                  pos_x_in = req_chan.pose_x;
                  pos_y_in = req_chan.pose_y;
                  head_in  = req_chan.pose_heading;
                  v_tmp    = clamp25({req_chan.pose_velocity[23], req_chan.pose_velocity},
                                     {minv_ff[23], minv_ff}, {2'b00, maxf_ff});
                  wl_in    = v_tmp[23:0];
                  state_in = ST_LOAD;
               end else begin
                  v_tmp    = clamp25({req_chan.lin_cmd[23], req_chan.lin_cmd},
                                     {minv_ff[23], minv_ff}, {2'b00, maxf_ff});
                  wl_in    = v_tmp[23:0];
                  v_tmp    = clamp25({req_chan.ang_cmd[23], req_chan.ang_cmd},
                                     -{2'b00, maxa_ff}, {2'b00, maxa_ff});
                  wa_in    = v_tmp[23:0];
                  state_in = ST_OFF;
               end
            end
         end
         ST_LOAD: begin
            v_tmp    = clamp25({wl_ff[23], wl_ff}, -maxw_s, maxw_s);
            lin_in   = v_tmp[23:0];
            ang_in   = '0;
            lw_in    = v_tmp[23:0];
            rw_in    = v_tmp[23:0];
            state_in = ST_FINISH;
         end
         ST_OFF: begin
            state_in = ST_ABS;
         end
         ST_ABS: begin
            labs_in  = abs33(lsum);
            rabs_in  = abs33(rsum);
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            peak_in = (labs_ff > rabs_ff) ? labs_ff : rabs_ff;
            if (((labs_ff > rabs_ff) ? labs_ff : rabs_ff) > {10'b0, maxw_ff}) begin
               state_in = ST_DIVL_GO;
            end else begin
               state_in = pass_ff ? ST_SUMS : ST_RATE;
            end
         end
         ST_DIVL_GO: begin
            state_in = ST_DIVL_WT;
         end
         ST_DIVL_WT: begin
            if (div_done) begin
               wl_in    = div_quot;
               state_in = ST_DIVA_GO;
            end
         end
         ST_DIVA_GO: begin
            state_in = ST_DIVA_WT;
         end
         ST_DIVA_WT: begin
            if (div_done) begin
               wa_in    = div_quot;
               state_in = pass_ff ? ST_SUMS : ST_RATE;
            end
         end
         ST_RATE: begin
            // move toward the targets, then rescale once more
            wl_in    = rate_step(lin_ff, wl_ff, lacc_ff, ldec_ff);
            wa_in    = rate_step(ang_ff, wa_ff, aacc_ff, aacc_ff);
            pass_in  = 1'b1;
            state_in = ST_OFF;
         end
         ST_SUMS: begin
            vsum_in  = {lin_ff[23], lin_ff} + {wl_ff[23], wl_ff};
            wsum_in  = {ang_ff[23], ang_ff} + {wa_ff[23], wa_ff};
            state_in = ST_MULW;
         end
         ST_MULW: begin
            state_in = ST_MID;
         end
         ST_MID: begin
            hdel_in  = sh_head[15:0];
            state_in = ST_CORD;
         end
         ST_CORD: begin
            if (cord_done) begin
               sin_in   = cord_sin;
               state_in = ST_POSX;
            end
         end
         ST_POSX: begin
            pos_x_in = sat32({pos_x_ff[31], pos_x_ff[31], pos_x_ff} + sh_pos[33:0]);
            state_in = ST_POSY;
         end
         ST_POSY: begin
            pos_y_in = sat32({pos_y_ff[31], pos_y_ff[31], pos_y_ff} + sh_pos[33:0]);
            head_in  = head_ff + hdel_ff;
            lin_in   = wl_ff;
            ang_in   = wa_ff;
            state_in = ST_WHEEL;
         end
         ST_WHEEL: begin
            lw_in    = sat24(lsum);
            rw_in    = sat24(rsum);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold here while the previous result is still waiting
            if (!rsp_valid_ff || rsp_chan.ready) begin
               ox_in        = pos_x_ff;
               oy_in        = pos_y_ff;
               oh_in        = head_ff;
               ol_in        = lin_ff;
               oa_in        = ang_ff;
               olw_in       = lw_ff;
               orw_in       = rw_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
         lin_ff       <= '0;
         ang_ff       <= '0;
         ht_ff        <= 23'd16384;
         maxf_ff      <= 23'd65536;
         minv_ff      <= '0;
         maxa_ff      <= 23'd65536;
         lacc_ff      <= 23'd256;
         ldec_ff      <= 23'd256;
         aacc_ff      <= 23'd256;
         maxw_ff      <= 23'd65536;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
         lin_ff       <= lin_in;
         ang_ff       <= ang_in;
         if (csr_we) begin
            case (csr_index)
               CSR_HALF_BASE:  ht_ff   <= csr_wdata[22:0];
               CSR_MAX_FWD:    maxf_ff <= csr_wdata[22:0];
               CSR_MIN_VEL:    minv_ff <= csr_wdata;
               CSR_MAX_ANG:    maxa_ff <= csr_wdata[22:0];
               CSR_LIN_ACCEL:  lacc_ff <= csr_wdata[22:0];
               CSR_LIN_DECEL:  ldec_ff <= csr_wdata[22:0];
               CSR_ANG_ACCEL:  aacc_ff <= csr_wdata[22:0];
               CSR_MAX_WHEEL:  maxw_ff <= csr_wdata[22:0];
               default: ;
            endcase
         end
      end
      prod_ff <= mul_a * mul_b;
      wl_ff   <= wl_in;
      wa_ff   <= wa_in;
      labs_ff <= labs_in;
      rabs_ff <= rabs_in;
      peak_ff <= peak_in;
      vsum_ff <= vsum_in;
      wsum_ff <= wsum_in;
      hdel_ff <= hdel_in;
      sin_ff  <= sin_in;
      lw_ff   <= lw_in;
      rw_ff   <= rw_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      oh_ff   <= oh_in;
      ol_ff   <= ol_in;
      oa_ff   <= oa_in;
      olw_ff  <= olw_in;
      orw_ff  <= orw_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_x       = ox_ff;
   assign rsp_chan.out_y       = oy_ff;
   assign rsp_chan.out_heading = oh_ff;
   assign rsp_chan.out_linear  = ol_ff;
   assign rsp_chan.out_angular = oa_ff;
   assign rsp_chan.left_wheel  = olw_ff;
   assign rsp_chan.right_wheel = orw_ff;
endmodule
`default_nettype wire

// ===== hdl/dd_kin_chk.sv =====
// port-level checker for the kinematics step block, with its bind
`default_nettype none
module dd_kin_chk (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                req_command,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire dd_kin_pkg::vel_type rsp_angular,
   input wire dd_kin_pkg::vel_type rsp_left,
   input wire dd_kin_pkg::vel_type rsp_right
);
   import dd_kin_pkg::*;

   // a waiting result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready high right after an accept");

   // load with an empty output reaches the output register after the load and finish states, no turn, equal wheels
   a_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command && !rsp_valid |-> ##3
      (rsp_valid && rsp_angular == 24'sd0 && rsp_left == rsp_right))
      else $error("load result wrong or late");
endmodule

bind diff_drive_kinematics_step dd_kin_chk u_dd_kin_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_command (req_chan.command),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_angular (rsp_chan.out_angular),
   .rsp_left    (rsp_chan.left_wheel),
   .rsp_right   (rsp_chan.right_wheel)
);
`default_nettype wire
